// ===== rtl/assert_macros.svh =====
// Shared assertion macros; clock and reset are taken as clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define Q2R_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2r assertion failed");

// Next-cycle implication
`define Q2R_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q2r assertion failed");

`endif

// ===== rtl/q2r_pkg.sv =====
package q2r_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int TOL_W      = 2 * FRAC_BITS;

  // Squared norm and square root sizing
  localparam int SQ_W        = 2 * COMP_WIDTH + 2;
  localparam int ROOT_BITS   = SQ_W / 2;
  localparam int STEPS_PER   = 3;
  localparam int SQRT_STAGES = (ROOT_BITS + STEPS_PER - 1) / STEPS_PER;
  localparam int SQRT_ITER   = SQRT_STAGES * STEPS_PER;
  localparam int RAD_W       = 2 * SQRT_ITER;
  localparam int REM_W       = SQRT_ITER + 3;

  // Division sizing
  localparam int DIV_STAGES = (COMP_WIDTH + STEPS_PER - 1) / STEPS_PER;
  localparam int DIV_ITER   = DIV_STAGES * STEPS_PER;
  localparam int DW         = SQRT_ITER + DIV_ITER + 1;

  // Matrix element sizing
  localparam int PROD_W = 2 * COMP_WIDTH;
  localparam int ELEM_W = 2 * COMP_WIDTH + 4;

  localparam logic [COMP_WIDTH-1:0] CLAMP = COMP_WIDTH'(1) << (COMP_WIDTH - 1);
  localparam logic [COMP_WIDTH-1:0] C_MAX = CLAMP - COMP_WIDTH'(1);
  localparam logic signed [ELEM_W-1:0] E_ONE  = ELEM_W'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [ELEM_W-1:0] E_HALF = ELEM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ELEM_W-1:0] E_MAX  = ELEM_W'(C_MAX);
  localparam logic signed [ELEM_W-1:0] E_MIN  = -E_MAX - ELEM_W'(1);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(26844);

  typedef logic [COMP_WIDTH-1:0] comp_t;

  typedef struct packed {
    logic [3:0][COMP_WIDTH-1:0] q;
    logic                       zero;
    logic                       renorm;
  } quat_t;

endpackage

// ===== rtl/q2r_norm.sv =====
module q2r_norm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  q2r_pkg::quat_t             in_item,
  input  logic [q2r_pkg::SQ_W-1:0]   in_r2,
  output logic                       out_valid,
  output q2r_pkg::quat_t             out_item
);

  localparam int NS = q2r_pkg::SQRT_STAGES;
  localparam int ND = q2r_pkg::DIV_STAGES;
  localparam int SP = q2r_pkg::STEPS_PER;
  localparam int W  = q2r_pkg::COMP_WIDTH;

  // Square root pipeline registers
  logic                             sq_v_r    [NS];
  q2r_pkg::quat_t                   sq_it_r   [NS];
  logic [q2r_pkg::RAD_W-1:0]        sq_rad_r  [NS];
  logic [q2r_pkg::REM_W-1:0]        sq_rem_r  [NS];
  logic [q2r_pkg::SQRT_ITER-1:0]    sq_root_r [NS];
  q2r_pkg::quat_t                   sq_it_nxt [NS];
  logic [q2r_pkg::RAD_W-1:0]        sq_rad_nxt[NS];
  logic [q2r_pkg::REM_W-1:0]        sq_rem_nxt[NS];
  logic [q2r_pkg::SQRT_ITER-1:0]    sq_root_nxt[NS];

  // Divider setup and pipeline registers
  logic                             ds_v_r;
  q2r_pkg::quat_t                   ds_it_r;
  logic [q2r_pkg::DW-1:0]           ds_s_r;
  logic [3:0][q2r_pkg::DW-1:0]      ds_num_r;
  logic [3:0]                       ds_big_r;
  logic                             dv_v_r   [ND];
  q2r_pkg::quat_t                   dv_it_r  [ND];
  logic [q2r_pkg::DW-1:0]           dv_s_r   [ND];
  logic [3:0]                       dv_big_r [ND];
  logic [3:0][q2r_pkg::DW-1:0]      dv_rem_r [ND];
  logic [3:0][q2r_pkg::DIV_ITER-1:0] dv_quo_r[ND];
  logic [3:0][q2r_pkg::DW-1:0]      dv_rem_nxt[ND];
  logic [3:0][q2r_pkg::DIV_ITER-1:0] dv_quo_nxt[ND];

  logic                             nf_v_r;
  q2r_pkg::quat_t                   nf_it_r;
  q2r_pkg::quat_t                   nf_it_nxt;
  logic [3:0][q2r_pkg::DW-1:0]      ds_num_nxt;
  logic [3:0]                       ds_big_nxt;

  // Sqrt steps: two radicand bits in, one root bit out per step
  always_comb begin
    logic [q2r_pkg::RAD_W-1:0]     rad;
    logic [q2r_pkg::REM_W-1:0]     rem;
    logic [q2r_pkg::SQRT_ITER-1:0] root;
    logic [q2r_pkg::REM_W+1:0]     rem2;
    logic [q2r_pkg::REM_W+1:0]     trial;
    for (int st = 0; st < NS; st++) begin
      if (st == 0) begin
        rad  = q2r_pkg::RAD_W'(in_r2);
        rem  = '0;
        root = '0;
        sq_it_nxt[st] = in_item;
      end else begin
        rad  = sq_rad_r[st-1];
        rem  = sq_rem_r[st-1];
        root = sq_root_r[st-1];
        sq_it_nxt[st] = sq_it_r[st-1];
      end
      for (int b = 0; b < SP; b++) begin
        rem2  = {rem, rad[q2r_pkg::RAD_W-1 -: 2]};
        rad   = rad << 2;
        trial = (q2r_pkg::REM_W + 2)'({root, 2'b01});
        if (rem2 >= trial) begin
          rem  = q2r_pkg::REM_W'(rem2 - trial);
          root = {root[q2r_pkg::SQRT_ITER-2:0], 1'b1};
        end else begin
          rem  = q2r_pkg::REM_W'(rem2);
          root = {root[q2r_pkg::SQRT_ITER-2:0], 1'b0};
        end
      end
      sq_rad_nxt[st]  = rad;
      sq_rem_nxt[st]  = rem;
      sq_root_nxt[st] = root;
    end
  end

  // Divider setup: rounded numerator and overflow check per component
  always_comb begin
    logic [W-1:0] m;
    logic [q2r_pkg::DW-1:0] s;
    s = q2r_pkg::DW'(sq_root_r[NS-1]);
    for (int i = 0; i < 4; i++) begin
      m = sq_it_r[NS-1].q[i][W-1] ? (~sq_it_r[NS-1].q[i] + W'(1)) : sq_it_r[NS-1].q[i];
      ds_num_nxt[i] = (q2r_pkg::DW'(m) << q2r_pkg::FRAC_BITS) + (s >> 1);
      ds_big_nxt[i] = ds_num_nxt[i] >= (s << q2r_pkg::DIV_ITER);
    end
  end

  // Restoring division steps, one quotient bit each
  always_comb begin
    logic [q2r_pkg::DW-1:0]       rem;
    logic [q2r_pkg::DIV_ITER-1:0] quo;
    logic [q2r_pkg::DW-1:0]       s;
    for (int st = 0; st < ND; st++) begin
      for (int i = 0; i < 4; i++) begin
        if (st == 0) begin
          rem = ds_num_r[i];
          quo = '0;
          s   = ds_s_r;
        end else begin
          rem = dv_rem_r[st-1][i];
          quo = dv_quo_r[st-1][i];
          s   = dv_s_r[st-1];
        end
        for (int b = 0; b < SP; b++) begin
          if (rem >= (s << (q2r_pkg::DIV_ITER - 1 - (st * SP + b)))) begin
            rem = rem - (s << (q2r_pkg::DIV_ITER - 1 - (st * SP + b)));
            quo = {quo[q2r_pkg::DIV_ITER-2:0], 1'b1};
          end else begin
            quo = {quo[q2r_pkg::DIV_ITER-2:0], 1'b0};
          end
        end
        dv_rem_nxt[st][i] = rem;
        dv_quo_nxt[st][i] = quo;
      end
    end
  end

  // Clamp, restore sign and pick normalized or raw components
  always_comb begin
    logic [W-1:0] m;
    logic         neg;
    nf_it_nxt = dv_it_r[ND-1];
    for (int i = 0; i < 4; i++) begin
      neg = dv_it_r[ND-1].q[i][W-1];
      if (dv_big_r[ND-1][i] ||
          dv_quo_r[ND-1][i] > q2r_pkg::DIV_ITER'(q2r_pkg::CLAMP)) begin
        m = q2r_pkg::CLAMP;
      end else begin
        m = W'(dv_quo_r[ND-1][i]);
      end
      if (dv_it_r[ND-1].renorm) begin
        if (neg) begin
          nf_it_nxt.q[i] = ~m + W'(1);
        end else if (m == q2r_pkg::CLAMP) begin
          nf_it_nxt.q[i] = q2r_pkg::C_MAX;
        end else begin
          nf_it_nxt.q[i] = m;
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int st = 0; st < NS; st++) sq_v_r[st] <= 1'b0;
      for (int st = 0; st < ND; st++) dv_v_r[st] <= 1'b0;
      ds_v_r <= 1'b0;
      nf_v_r <= 1'b0;
    end else begin
      sq_v_r[0] <= in_valid;
      for (int st = 1; st < NS; st++) sq_v_r[st] <= sq_v_r[st-1];
      ds_v_r    <= sq_v_r[NS-1];
      dv_v_r[0] <= ds_v_r;
      for (int st = 1; st < ND; st++) dv_v_r[st] <= dv_v_r[st-1];
      nf_v_r    <= dv_v_r[ND-1];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int st = 0; st < NS; st++) begin
      sq_it_r[st]   <= sq_it_nxt[st];
      sq_rad_r[st]  <= sq_rad_nxt[st];
      sq_rem_r[st]  <= sq_rem_nxt[st];
      sq_root_r[st] <= sq_root_nxt[st];
    end
    ds_it_r  <= sq_it_r[NS-1];
    ds_s_r   <= q2r_pkg::DW'(sq_root_r[NS-1]);
    ds_num_r <= ds_num_nxt;
    ds_big_r <= ds_big_nxt;
    for (int st = 0; st < ND; st++) begin
      dv_it_r[st]  <= (st == 0) ? ds_it_r  : dv_it_r[st == 0 ? 0 : st-1];
      dv_s_r[st]   <= (st == 0) ? ds_s_r   : dv_s_r[st == 0 ? 0 : st-1];
      dv_big_r[st] <= (st == 0) ? ds_big_r : dv_big_r[st == 0 ? 0 : st-1];
      dv_rem_r[st] <= dv_rem_nxt[st];
      dv_quo_r[st] <= dv_quo_nxt[st];
    end
    nf_it_r <= nf_it_nxt;
  end

  assign out_valid = nf_v_r;
  assign out_item  = nf_it_r;

endmodule

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix.
// Input: one quaternion (in_qw, in_qx, in_qy, in_qz, signed Q1.14) is taken
// at a rising edge with start high and busy low. busy stays high after an accept
// until gap_r counts down to zero, so a new quaternion waits out that gap.
// Output: each quaternion yields three rows, one after another, each held
// for one cycle with out_valid high: out_row_index 0, 1, 2, elements
// out_elem_a/b/c (Q1.14, saturated), flags, and out_last_row on row 2.
// Throughput is set by the single result channel carrying three rows per
// quaternion; a new quaternion may enter while earlier ones are in flight.
// The pipeline runs squares, norm, a 6-stage square root (3 root bits a
// stage), a 6-stage divider (3 quotient bits a stage), products, sums and
// rounding.
// Configuration: cfg_we writes cfg_wdata into the renormalization tolerance
// (Q0.28); write only while no quaternion is in flight.
// Reset (rst_n low, synchronous) clears all valid bits, the sequencer and
// busy, and restores the tolerance to its default.
// The receiver cannot stall: every row is taken in its cycle.
`include "assert_macros.svh"

module quaternion_to_rotation_matrix (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [q2r_pkg::COMP_WIDTH-1:0] in_qw,
  input  logic signed [q2r_pkg::COMP_WIDTH-1:0] in_qx,
  input  logic signed [q2r_pkg::COMP_WIDTH-1:0] in_qy,
  input  logic signed [q2r_pkg::COMP_WIDTH-1:0] in_qz,
  input  logic                               cfg_we,
  input  logic [q2r_pkg::TOL_W-1:0]          cfg_wdata,
  output logic                               out_valid,
  output logic [1:0]                         out_row_index,
  output logic signed [q2r_pkg::COMP_WIDTH-1:0] out_elem_a,
  output logic signed [q2r_pkg::COMP_WIDTH-1:0] out_elem_b,
  output logic signed [q2r_pkg::COMP_WIDTH-1:0] out_elem_c,
  output logic                               out_was_renormalized,
  output logic                               out_zero_input,
  output logic                               out_last_row
);

  localparam int W  = q2r_pkg::COMP_WIDTH;
  localparam int PW = q2r_pkg::PROD_W;
  localparam int EW = q2r_pkg::ELEM_W;

  logic                      accept;
  logic [1:0]                gap_r;
  logic [q2r_pkg::TOL_W-1:0] tol_r;

  logic                      s0_v_r, s1_v_r, s2_v_r;
  q2r_pkg::quat_t            s0_it_r, s1_it_r, s2_it_r, s2_it_nxt;
  logic [3:0][PW-1:0]        s1_sq_r;
  logic [q2r_pkg::SQ_W-1:0]  s2_r2_r, s2_r2_nxt;

  logic                      nq_v;
  q2r_pkg::quat_t            nq_it;

  logic                      pr_v_r;
  logic                      pr_zero_r, pr_ren_r;
  logic signed [PW-1:0]      p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_xz_r, p_yz_r;
  logic signed [PW-1:0]      p_wx_r, p_wy_r, p_wz_r;

  logic                      el_v_r;
  logic                      el_zero_r, el_ren_r;
  logic signed [EW-1:0]      el_r   [3][3];
  logic signed [EW-1:0]      el_nxt [3][3];

  logic                      sq_act_r;
  logic [1:0]                row_r;
  logic                      buf_zero_r, buf_ren_r;
  logic [W-1:0]              buf_r   [3][3];
  logic [W-1:0]              buf_nxt [3][3];

  assign accept = start && !busy;
  assign busy   = gap_r != 2'd0;

  // Hold off the next quaternion after each accept until gap_r reaches zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (accept) begin
      gap_r <= 2'd2;
    end else if (gap_r != 2'd0) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= q2r_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // Squared norm and renormalization decision
  always_comb begin
    logic [q2r_pkg::SQ_W-1:0] diff;
    logic [q2r_pkg::SQ_W-1:0] one;
    one       = q2r_pkg::SQ_W'(1) << (2 * q2r_pkg::FRAC_BITS);
    s2_r2_nxt = q2r_pkg::SQ_W'(s1_sq_r[0]) + q2r_pkg::SQ_W'(s1_sq_r[1])
              + q2r_pkg::SQ_W'(s1_sq_r[2]) + q2r_pkg::SQ_W'(s1_sq_r[3]);
    diff      = (s2_r2_nxt >= one) ? s2_r2_nxt - one : one - s2_r2_nxt;
    s2_it_nxt        = s1_it_r;
    s2_it_nxt.zero   = s2_r2_nxt == '0;
    s2_it_nxt.renorm = (s2_r2_nxt != '0) && (diff >= q2r_pkg::SQ_W'(tol_r));
  end

  // Front stages: capture, square, sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= accept;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_it_r.q      <= {in_qz, in_qy, in_qx, in_qw};
    s0_it_r.zero   <= 1'b0;
    s0_it_r.renorm <= 1'b0;
    s1_it_r        <= s0_it_r;
    for (int i = 0; i < 4; i++) begin
      s1_sq_r[i] <= PW'($signed(s0_it_r.q[i]) * $signed(s0_it_r.q[i]));
    end
    s2_it_r <= s2_it_nxt;
    s2_r2_r <= s2_r2_nxt;
  end

  q2r_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_item   (s2_it_r),
    .in_r2     (s2_r2_r),
    .out_valid (nq_v),
    .out_item  (nq_it)
  );

  // Element sums at double fraction width
  always_comb begin
    el_nxt[0][0] = q2r_pkg::E_ONE - (EW'(p_yy_r) <<< 1) - (EW'(p_zz_r) <<< 1);
    el_nxt[0][1] = (EW'(p_xy_r) <<< 1) + (EW'(p_wz_r) <<< 1);
    el_nxt[0][2] = (EW'(p_xz_r) <<< 1) - (EW'(p_wy_r) <<< 1);
    el_nxt[1][0] = (EW'(p_xy_r) <<< 1) - (EW'(p_wz_r) <<< 1);
    el_nxt[1][1] = q2r_pkg::E_ONE - (EW'(p_xx_r) <<< 1) - (EW'(p_zz_r) <<< 1);
    el_nxt[1][2] = (EW'(p_yz_r) <<< 1) + (EW'(p_wx_r) <<< 1);
    el_nxt[2][0] = (EW'(p_xz_r) <<< 1) + (EW'(p_wy_r) <<< 1);
    el_nxt[2][1] = (EW'(p_yz_r) <<< 1) - (EW'(p_wx_r) <<< 1);
    el_nxt[2][2] = q2r_pkg::E_ONE - (EW'(p_xx_r) <<< 1) - (EW'(p_yy_r) <<< 1);
  end

  // Round to nearest, ties up, then saturate
  always_comb begin
    logic signed [EW-1:0] t;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        t = (el_r[r][c] + q2r_pkg::E_HALF) >>> q2r_pkg::FRAC_BITS;
        if (t > q2r_pkg::E_MAX) begin
          buf_nxt[r][c] = q2r_pkg::C_MAX;
        end else if (t < q2r_pkg::E_MIN) begin
          buf_nxt[r][c] = q2r_pkg::CLAMP;
        end else begin
          buf_nxt[r][c] = t[W-1:0];
        end
      end
    end
  end

  // Back stages: products, sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
      el_v_r <= 1'b0;
    end else begin
      pr_v_r <= nq_v;
      el_v_r <= pr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p_xx_r <= $signed(nq_it.q[1]) * $signed(nq_it.q[1]);
    p_yy_r <= $signed(nq_it.q[2]) * $signed(nq_it.q[2]);
    p_zz_r <= $signed(nq_it.q[3]) * $signed(nq_it.q[3]);
    p_xy_r <= $signed(nq_it.q[1]) * $signed(nq_it.q[2]);
    p_xz_r <= $signed(nq_it.q[1]) * $signed(nq_it.q[3]);
    p_yz_r <= $signed(nq_it.q[2]) * $signed(nq_it.q[3]);
    p_wx_r <= $signed(nq_it.q[0]) * $signed(nq_it.q[1]);
    p_wy_r <= $signed(nq_it.q[0]) * $signed(nq_it.q[2]);
    p_wz_r <= $signed(nq_it.q[0]) * $signed(nq_it.q[3]);
    pr_zero_r <= nq_it.zero;
    pr_ren_r  <= nq_it.renorm;
    el_r      <= el_nxt;
    el_zero_r <= pr_zero_r;
    el_ren_r  <= pr_ren_r;
  end

  // Row sequencer: load a finished matrix, then emit three rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_act_r <= 1'b0;
      row_r    <= 2'd0;
    end else if (el_v_r) begin
      sq_act_r <= 1'b1;
      row_r    <= 2'd0;
    end else if (sq_act_r) begin
      if (row_r == 2'd2) begin
        sq_act_r <= 1'b0;
      end else begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (el_v_r) begin
      buf_r      <= buf_nxt;
      buf_zero_r <= el_zero_r;
      buf_ren_r  <= el_ren_r;
    end
  end

  // Drive the current row
  always_comb begin
    out_elem_a = '0;
    out_elem_b = '0;
    out_elem_c = '0;
    unique case (row_r)
      2'd0: begin
        out_elem_a = buf_r[0][0];
        out_elem_b = buf_r[0][1];
        out_elem_c = buf_r[0][2];
      end
      2'd1: begin
        out_elem_a = buf_r[1][0];
        out_elem_b = buf_r[1][1];
        out_elem_c = buf_r[1][2];
      end
      2'd2: begin
        out_elem_a = buf_r[2][0];
        out_elem_b = buf_r[2][1];
        out_elem_c = buf_r[2][2];
      end
      default: begin
        out_elem_a = '0;
      end
    endcase
  end

  assign out_valid            = sq_act_r;
  assign out_row_index        = row_r;
  assign out_was_renormalized = buf_ren_r;
  assign out_zero_input       = buf_zero_r;
  assign out_last_row         = row_r == 2'd2;

  `Q2R_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  `Q2R_ASSERT_NEXT(a_rows_run_on, out_valid && !out_last_row, out_valid)
  `Q2R_ASSERT_SAME(a_zero_not_renorm, out_valid && out_zero_input, !out_was_renormalized)
  `Q2R_ASSERT_SAME(a_no_load_mid_rows, el_v_r, !sq_act_r || out_last_row)

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 20;
  localparam int CYCLE_CAP = 400000;

  typedef struct packed {
    logic [1:0]                     row;
    logic [q2r_pkg::COMP_WIDTH-1:0] a;
    logic [q2r_pkg::COMP_WIDTH-1:0] b;
    logic [q2r_pkg::COMP_WIDTH-1:0] c;
    logic                           renorm;
    logic                           zero;
    logic                           last;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [q2r_pkg::COMP_WIDTH-1:0] in_qw = '0, in_qx = '0, in_qy = '0, in_qz = '0;
  logic cfg_we = 1'b0;
  logic [q2r_pkg::TOL_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [1:0] out_row_index;
  logic signed [q2r_pkg::COMP_WIDTH-1:0] out_elem_a, out_elem_b, out_elem_c;
  logic out_was_renormalized, out_zero_input, out_last_row;

  row_t        pending_rows[$];
  logic [27:0] tolerance = q2r_pkg::TOL_RESET;
  int          mismatches = 0;
  int          rows_seen = 0;
  int          quats_sent = 0;
  int          renorm_seen = 0;
  longint      cycles = 0;

  quaternion_to_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_qw(in_qw), .in_qx(in_qx), .in_qy(in_qy), .in_qz(in_qz),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_row_index(out_row_index),
    .out_elem_a(out_elem_a), .out_elem_b(out_elem_b), .out_elem_c(out_elem_c),
    .out_was_renormalized(out_was_renormalized), .out_zero_input(out_zero_input),
    .out_last_row(out_last_row)
  );

  always #10 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Round from 2F to F fraction bits, ties up, then clamp
  function automatic logic [q2r_pkg::COMP_WIDTH-1:0] round_elem(longint e);
    longint t = e + (64'sd1 <<< (q2r_pkg::FRAC_BITS - 1));
    longint r = t >>> q2r_pkg::FRAC_BITS;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[q2r_pkg::COMP_WIDTH-1:0];
  endfunction

  // Work out the three rows for one quaternion and queue them
  task automatic predict_rows(logic signed [15:0] w0, x0, y0, z0);
    longint q[4];
    longint unsigned r2, diff, s, m;
    longint one = 64'sd1 <<< (2 * q2r_pkg::FRAC_BITS);
    longint e[9];
    logic zero, renorm;
    row_t r;
    q[0] = w0; q[1] = x0; q[2] = y0; q[3] = z0;
    r2 = 0;
    for (int i = 0; i < 4; i++) r2 += q[i] * q[i];
    zero = (r2 == 0);
    renorm = 1'b0;
    if (!zero) begin
      diff = (r2 >= one) ? r2 - one : one - r2;
      if (diff >= tolerance) begin
        renorm = 1'b1;
        s = int_sqrt(r2);
        for (int i = 0; i < 4; i++) begin
          m = (((q[i] < 0 ? -q[i] : q[i]) << q2r_pkg::FRAC_BITS) + (s >> 1)) / s;
          if (m > 32768) m = 32768;
          q[i] = (q[i] < 0) ? -longint'(m) : longint'(m);
          if (q[i] > 32767) q[i] = 32767;
        end
      end
    end
    e[0] = one - 2*q[2]*q[2] - 2*q[3]*q[3];
    e[1] = 2*q[1]*q[2] + 2*q[0]*q[3];
    e[2] = 2*q[1]*q[3] - 2*q[0]*q[2];
    e[3] = 2*q[1]*q[2] - 2*q[0]*q[3];
    e[4] = one - 2*q[1]*q[1] - 2*q[3]*q[3];
    e[5] = 2*q[2]*q[3] + 2*q[0]*q[1];
    e[6] = 2*q[1]*q[3] + 2*q[0]*q[2];
    e[7] = 2*q[2]*q[3] - 2*q[0]*q[1];
    e[8] = one - 2*q[1]*q[1] - 2*q[2]*q[2];
    for (int k = 0; k < 3; k++) begin
      r.row = k[1:0];
      r.a = round_elem(e[3*k]);
      r.b = round_elem(e[3*k+1]);
      r.c = round_elem(e[3*k+2]);
      r.renorm = renorm;
      r.zero = zero;
      r.last = (k == 2);
      pending_rows.push_back(r);
    end
  endtask

  // Compare each row with the oldest expectation
  always @(posedge clk) begin
    row_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_row_index, out_elem_a, out_elem_b, out_elem_c,
              out_was_renormalized, out_zero_input, out_last_row};
      rows_seen++;
      if (out_was_renormalized) renorm_seen++;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row %p", got);
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("row mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Send one quaternion after a random gap; start stays low over the edge
  // after the previous accept, while busy holds the block anyway
  task automatic send_quat(logic [15:0] w, x, y, z, bit gaps = 1);
    int gap = gaps ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(posedge clk);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_qw <= w; in_qx <= x; in_qy <= y; in_qz <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_rows(w, x, y, z);
    quats_sent++;
    start <= 1'b0;
  endtask

  task automatic drain;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [27:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance = v;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 16384));
      3: return -16'($urandom_range(0, 16384));
      default: return 16'($urandom());
    endcase
  endfunction

  // Extremes, zero, identity and minus-two components at reset tolerance
  task automatic test_directed;
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(16'h8000, 0, 0, 0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(0, 0, 0, 1);
    send_quat(16'hffff, 0, 0, 0);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -16'sd8192, 8192, -16'sd8192);
    send_quat(11585, 11585, 0, 0);
    send_quat(16384, 1, 0, 0);
    send_quat(0, 16'h8000, 0, 16'h7fff, 0);
    send_quat(16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 0);
    drain();
  endtask

  // Zero tolerance renormalises everything nonzero
  task automatic test_zero_tolerance;
    set_tolerance(28'd0);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(100, 0, 0, 0);
    for (int i = 0; i < 60; i++) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // Maximum tolerance renormalises only squared norms far from one
  task automatic test_max_tolerance;
    set_tolerance(28'h0ffffff + 28'hf000000);
    for (int i = 0; i < 60; i++) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // Random tolerances with below-unit and wild quaternions, then the reset one
  task automatic test_random;
    for (int p = 0; p < 6; p++) begin
      set_tolerance(p[0] ? 28'($urandom()) : 28'($urandom_range(0, 100000)));
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 1)) begin
          send_quat(16'($urandom_range(0, 9460)) - 16'd4730, 16'($urandom_range(0, 9460)) - 16'd4730,
                    16'($urandom_range(0, 9460)) - 16'd4730, 16'($urandom_range(0, 200)) + 16'd8100);
        end else begin
          send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
        if (i == 20) while (pending_rows.size() != 0) @(posedge clk);
      end
    end
    set_tolerance(q2r_pkg::TOL_RESET);
    for (int i = 0; i < 40; i++) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_tolerance();
    test_max_tolerance();
    test_random();
    drain();
    $display("tb: %0d quaternions sent, %0d rows checked, %0d renormalised rows",
             quats_sent, rows_seen, renorm_seen);
    $display("tb: tolerances covered zero, maximum, reset and random values");
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
